FILE: design/rmdc_pkg.sv
// Package for the radio mailbox duty cycler: payload structs, event opcodes,
// register indexes, phase and start-origin codes, and the wrapping time compare.
// No dependencies.
package rmdc_pkg;

  localparam int unsigned MAX_WRITE_BYTES = 512;
  localparam logic [15:0] MS_PER_MINUTE = 16'd60000;
  localparam int unsigned INTERVAL_MS_W = 24;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAILBOX_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_MIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LINK_TIMEOUT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GRACE_MS = 3'd4;
  localparam int unsigned CFG_DATA_W = 16;

  // Reset values of the configuration registers.
  localparam logic [15:0] WINDOW_MS_RST = 16'd5000;
  localparam logic [15:0] LINK_TIMEOUT_RST = 16'd5000;
  localparam logic [15:0] GRACE_MS_RST = 16'd1000;

  // Event opcodes.
  localparam logic [3:0] OP_START = 4'd0;
  localparam logic [3:0] OP_STOP = 4'd1;
  localparam logic [3:0] OP_TICK = 4'd2;
  localparam logic [3:0] OP_CONNECT = 4'd3;
  localparam logic [3:0] OP_DISCONNECT = 4'd4;
  localparam logic [3:0] OP_PAYLOAD = 4'd5;
  localparam logic [3:0] OP_SUSPEND = 4'd6;
  localparam logic [3:0] OP_RESUME = 4'd7;
  localparam logic [3:0] OP_RADIO_DONE = 4'd8;
  localparam logic [3:0] OP_ADV_DONE = 4'd9;
  localparam logic [3:0] OP_DISC_DONE = 4'd10;
  localparam logic [3:0] OP_QUERY = 4'd11;

  // Phase codes.
  localparam logic [1:0] PH_NORMAL = 2'd0;
  localparam logic [1:0] PH_WINDOW = 2'd1;
  localparam logic [1:0] PH_WAITING = 2'd2;

  // Origin of a pending radio start.
  localparam logic [1:0] ORG_NONE = 2'd0;
  localparam logic [1:0] ORG_START = 2'd1;
  localparam logic [1:0] ORG_RESUME = 2'd2;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [31:0] now_ms;
    logic [15:0] link_id;
    logic [9:0]  write_length;
    logic        op_ok;
  } in_t;

  typedef struct packed {
    logic        accepted;
    logic        start_radio;
    logic        shut_radio;
    logic        start_adv;
    logic        stop_adv;
    logic        drop_link;
    logic [15:0] drop_link_id;
    logic        is_linked;
    logic        is_waiting;
    logic [31:0] sleep_left_ms;
    logic        is_running;
    logic        radio_on;
  } out_t;

  // A time stamp counts as reached once now minus target is non-negative
  // as a signed 32-bit value.
  function automatic logic reached(input logic [31:0] now, input logic [31:0] target);
    logic [31:0] diff;
    diff = now - target;
    return ~diff[31];
  endfunction

endpackage

FILE: design/radio_mailbox_duty_cycler_top.sv
// Top level of the radio mailbox duty cycler: input register, event decode and
// state update, result register. Depends on rmdc_pkg.
//
// Usage: events enter on the in channel (in_valid/in_ready, payload in_data)
// and each event yields exactly one result on the out channel
// (out_valid/out_ready, payload out_data), in order. A transfer happens on a
// rising edge with valid and ready both high.
// An accepted event is held in the input register, then its result is loaded
// into the result register once that register is empty or being read, and
// out_valid rises with it. Throughput is one event per cycle while the receiver
// takes every result; the event decode, wrapping time compares and state update
// all sit in one combinational pass between the input and result registers.
// If the receiver stalls, the result register holds its value and the input
// register holds at most one more event; in_ready falls once both are full.
// Configuration registers are written through cfg_we/cfg_index/cfg_data, one
// write per cycle; the user writes only while no event is in flight, which the
// block does not enforce. The interval is converted from minutes to ms on write.
// Synchronous reset (rst) empties both registers, stops the controller and
// returns the configuration to its defaults.
module radio_mailbox_duty_cycler_top #(
  parameter int unsigned MAX_WRITE_BYTES = rmdc_pkg::MAX_WRITE_BYTES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  rmdc_pkg::in_t                in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output rmdc_pkg::out_t               out_data,
  input  logic                         cfg_we,
  input  logic [rmdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rmdc_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned IW = rmdc_pkg::INTERVAL_MS_W;

  // Configuration.
  logic          mailbox_mode;
  logic [IW-1:0] interval_ms;
  logic [15:0]   window_ms;
  logic [15:0]   link_timeout_ms;
  logic [15:0]   grace_ms;

  // Pipeline registers.
  logic           in_vld;
  rmdc_pkg::in_t  in_q;
  logic           proc;

  // Controller state.
  logic          run_flag, run_flag_next;
  logic          radio_flag, radio_flag_next;
  logic          link_flag, link_flag_next;
  logic          drop_pending, drop_pending_next;
  logic          adv_pending, adv_pending_next;
  logic          drop_valid, drop_valid_next;
  logic          mode_q, mode_q_next;
  logic [1:0]    phase, phase_next;
  logic [1:0]    start_origin, start_origin_next;
  logic [15:0]   held_link_id, held_link_id_next;
  logic [IW-1:0] interval_q, interval_q_next;
  logic [31:0]   window_start, window_start_next;
  logic [31:0]   next_window, next_window_next;
  logic [31:0]   link_start, link_start_next;
  logic [31:0]   drop_after, drop_after_next;

  rmdc_pkg::out_t res;
  logic [31:0]    now;
  logic [31:0]    sleep_diff;
  logic           waiting;
  logic           len_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      mailbox_mode    <= 1'b0;
      interval_ms     <= '0;
      window_ms       <= rmdc_pkg::WINDOW_MS_RST;
      link_timeout_ms <= rmdc_pkg::LINK_TIMEOUT_RST;
      grace_ms        <= rmdc_pkg::GRACE_MS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rmdc_pkg::CFG_MAILBOX_MODE: mailbox_mode <= cfg_data[0];
        rmdc_pkg::CFG_INTERVAL_MIN: begin
          interval_ms <= IW'(cfg_data[7:0]) * IW'(rmdc_pkg::MS_PER_MINUTE);
        end
        rmdc_pkg::CFG_WINDOW_MS:    window_ms <= cfg_data;
        rmdc_pkg::CFG_LINK_TIMEOUT: link_timeout_ms <= cfg_data;
        rmdc_pkg::CFG_GRACE_MS:     grace_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  assign proc     = in_vld && (!out_valid || out_ready);
  assign in_ready = !in_vld || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ready) begin
      in_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q <= in_data;
    end
  end

  assign now          = in_q.now_ms;
  assign len_ok       = (in_q.write_length != 10'd0) &&
                        (32'(in_q.write_length) <= 32'(MAX_WRITE_BYTES));

  always_comb begin
    run_flag_next     = run_flag;
    radio_flag_next   = radio_flag;
    link_flag_next    = link_flag;
    drop_pending_next = drop_pending;
    adv_pending_next  = adv_pending;
    drop_valid_next   = drop_valid;
    mode_q_next       = mode_q;
    phase_next        = phase;
    start_origin_next = start_origin;
    held_link_id_next = held_link_id;
    interval_q_next   = interval_q;
    window_start_next = window_start;
    next_window_next  = next_window;
    link_start_next   = link_start;
    drop_after_next   = drop_after;
    res               = '0;

    unique case (in_q.opcode)
      rmdc_pkg::OP_START: begin
        res.accepted = 1'b1;
        if (!run_flag) begin
          run_flag_next     = 1'b1;
          radio_flag_next   = 1'b0;
          mode_q_next       = mailbox_mode;
          interval_q_next   = interval_ms;
          link_flag_next    = 1'b0;
          held_link_id_next = '0;
          drop_valid_next   = 1'b0;
          drop_after_next   = '0;
          drop_pending_next = 1'b0;
          phase_next        = mailbox_mode ? rmdc_pkg::PH_WINDOW : rmdc_pkg::PH_NORMAL;
          window_start_next = now;
          next_window_next  = '0;
          link_start_next   = '0;
          adv_pending_next  = 1'b0;
          start_origin_next = rmdc_pkg::ORG_START;
          res.start_radio   = 1'b1;
        end
      end
      rmdc_pkg::OP_STOP: begin
        if (run_flag) begin
          // A start still in flight counts as a running radio.
          res.shut_radio    = radio_flag || (start_origin != rmdc_pkg::ORG_NONE);
          run_flag_next     = 1'b0;
          radio_flag_next   = 1'b0;
          mode_q_next       = 1'b0;
          interval_q_next   = '0;
          link_flag_next    = 1'b0;
          held_link_id_next = '0;
          drop_valid_next   = 1'b0;
          drop_after_next   = '0;
          drop_pending_next = 1'b0;
          phase_next        = rmdc_pkg::PH_NORMAL;
          adv_pending_next  = 1'b0;
          start_origin_next = rmdc_pkg::ORG_NONE;
        end
      end
      rmdc_pkg::OP_TICK: begin
        if (run_flag && radio_flag) begin
          if (!mode_q) begin
            if (!link_flag && adv_pending) begin
              adv_pending_next = 1'b0;
              res.start_adv    = 1'b1;
            end
          end else if (phase == rmdc_pkg::PH_WINDOW) begin
            if (link_flag) begin
              if (((drop_valid && rmdc_pkg::reached(now, drop_after)) ||
                   rmdc_pkg::reached(now, link_start + 32'(link_timeout_ms))) &&
                  !drop_pending) begin
                drop_pending_next = 1'b1;
                res.drop_link     = 1'b1;
                res.drop_link_id  = held_link_id;
              end
            end else if (rmdc_pkg::reached(now, window_start + 32'(window_ms))) begin
              phase_next       = rmdc_pkg::PH_WAITING;
              next_window_next = now + 32'(interval_q);
              res.stop_adv     = 1'b1;
            end
          end
        end
      end
      rmdc_pkg::OP_CONNECT, rmdc_pkg::OP_DISCONNECT: begin
        if (run_flag && radio_flag) begin
          link_flag_next    = 1'b0;
          held_link_id_next = '0;
          drop_valid_next   = 1'b0;
          drop_after_next   = '0;
          drop_pending_next = 1'b0;
          if (in_q.opcode == rmdc_pkg::OP_CONNECT) begin
            link_flag_next    = 1'b1;
            held_link_id_next = in_q.link_id;
            link_start_next   = now;
            if (mode_q) begin
              phase_next        = rmdc_pkg::PH_WINDOW;
              window_start_next = now;
            end
          end else if (mode_q) begin
            phase_next       = rmdc_pkg::PH_WAITING;
            next_window_next = now + 32'(interval_q);
          end else begin
            adv_pending_next = 1'b1;
          end
        end
      end
      rmdc_pkg::OP_PAYLOAD: begin
        if (len_ok && mode_q && link_flag) begin
          drop_after_next   = now + 32'(grace_ms);
          drop_valid_next   = 1'b1;
          drop_pending_next = 1'b0;
        end
      end
      rmdc_pkg::OP_SUSPEND: begin
        if (run_flag && radio_flag && mode_q && !link_flag &&
            phase == rmdc_pkg::PH_WAITING) begin
          radio_flag_next  = 1'b0;
          adv_pending_next = 1'b0;
          res.shut_radio   = 1'b1;
          res.accepted     = 1'b1;
        end
      end
      rmdc_pkg::OP_RESUME: begin
        if (run_flag && !radio_flag && mode_q && phase == rmdc_pkg::PH_WAITING &&
            start_origin == rmdc_pkg::ORG_NONE && rmdc_pkg::reached(now, next_window)) begin
          phase_next        = rmdc_pkg::PH_WINDOW;
          window_start_next = now;
          start_origin_next = rmdc_pkg::ORG_RESUME;
          res.start_radio   = 1'b1;
          res.accepted      = 1'b1;
        end
      end
      rmdc_pkg::OP_RADIO_DONE: begin
        if (start_origin != rmdc_pkg::ORG_NONE) begin
          if (in_q.op_ok) begin
            radio_flag_next   = 1'b1;
            window_start_next = now;
            adv_pending_next  = 1'b0;
            res.accepted      = 1'b1;
          end else if (start_origin == rmdc_pkg::ORG_START) begin
            run_flag_next = 1'b0;
          end else begin
            // A failed reopen goes back to waiting for one more interval.
            phase_next       = rmdc_pkg::PH_WAITING;
            next_window_next = window_start + 32'(interval_q);
          end
          start_origin_next = rmdc_pkg::ORG_NONE;
        end
      end
      rmdc_pkg::OP_ADV_DONE: begin
        if (!in_q.op_ok && run_flag && radio_flag && !mode_q) begin
          adv_pending_next = 1'b1;
        end
      end
      rmdc_pkg::OP_DISC_DONE: begin
        if (!in_q.op_ok) begin
          drop_pending_next = 1'b0;
        end
      end
      rmdc_pkg::OP_QUERY: ;
      default: ;
    endcase

    waiting    = run_flag_next && mode_q_next && (phase_next == rmdc_pkg::PH_WAITING);
    sleep_diff = now - next_window_next;
    res.is_linked     = link_flag_next;
    res.is_waiting    = waiting;
    res.sleep_left_ms = (waiting && sleep_diff[31]) ? (32'd0 - sleep_diff) : 32'd0;
    res.is_running    = run_flag_next;
    res.radio_on      = radio_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_flag     <= 1'b0;
      radio_flag   <= 1'b0;
      link_flag    <= 1'b0;
      drop_pending <= 1'b0;
      adv_pending  <= 1'b0;
      drop_valid   <= 1'b0;
      mode_q       <= 1'b0;
      phase        <= rmdc_pkg::PH_NORMAL;
      start_origin <= rmdc_pkg::ORG_NONE;
      held_link_id <= '0;
      interval_q   <= '0;
      window_start <= '0;
      next_window  <= '0;
      link_start   <= '0;
      drop_after   <= '0;
    end else if (proc) begin
      run_flag     <= run_flag_next;
      radio_flag   <= radio_flag_next;
      link_flag    <= link_flag_next;
      drop_pending <= drop_pending_next;
      adv_pending  <= adv_pending_next;
      drop_valid   <= drop_valid_next;
      mode_q       <= mode_q_next;
      phase        <= phase_next;
      start_origin <= start_origin_next;
      held_link_id <= held_link_id_next;
      interval_q   <= interval_q_next;
      window_start <= window_start_next;
      next_window  <= next_window_next;
      link_start   <= link_start_next;
      drop_after   <= drop_after_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_data <= res;
    end
  end

endmodule
